// ----- rtl/core/perl_pkg.sv -----
// Shared types and codes of the priority evicting record log.
// No dependencies; every file of the block imports this package.
package perl_pkg;

    localparam int COST_W = 18;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_TAKE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_TAKE_DATA,
        S_PLAN_RD,
        S_PLAN_CHK,
        S_PACK_RD,
        S_PACK_WR,
        S_STORE
    } fsm_t;

    typedef struct packed {
        logic [31:0] ts;
        logic [15:0] len;
        logic [1:0]  pri;
        logic [3:0]  idx;
    } rec_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  event_index;
        logic [1:0]  priority_req;
        logic [15:0] payload_length;
        logic [31:0] timestamp_ms;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  out_event_index;
        logic [1:0]  out_priority;
        logic [15:0] out_length;
        logic [31:0] out_timestamp;
        logic [16:0] bytes_in_use;
        logic [8:0]  records_held;
    } rsp_t;

endpackage

// ----- rtl/core/priority_evicting_record_log_unit.sv -----
// Top level of the priority evicting record log: ring memory, sequencer, result register.
// Depends on perl_pkg.
//
// One request at a time. A store that fits goes through decide, then
// write, with the result registered as the write is made; a take does the
// same (decide, then read back). The next request is accepted once the
// block is idle again. A store that would exceed the budget first runs an
// eviction plan over the ring memory, up to three passes (low, normal,
// high) over the records held, each record read and then checked; if enough
// can be freed, a compaction pass follows that reads each record and writes
// back the survivors, and then the store itself. Every record is read
// through the memory's single read port. req_stall is high while a request
// is being worked; the result register holds one finished result so the
// next request can be accepted while it waits.
module priority_evicting_record_log_unit
    import perl_pkg::*;
#(
    parameter int MAX_RECORDS  = 256,
    parameter int HEADER_BYTES = 12,
    parameter int BUFFER_BYTES = 65536
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int SW = $clog2(MAX_RECORDS);
    localparam logic [20:0] BUF_CAP = 21'(BUFFER_BYTES);
    localparam logic [CW:0] DEPTH = (CW + 1)'(MAX_RECORDS);

    // ring memory of record headers
    rec_t mem [MAX_RECORDS];
    rec_t rd_data_reg;
    logic [SW-1:0] rd_addr, wr_addr;
    logic wr_en;
    rec_t wr_data;

    fsm_t state_reg, state_next;
    req_t item_reg;
    logic [16:0] budget_reg;
    logic [SW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [16:0] used_reg, used_next;
    logic [1:0] pass_reg, pass_next, stop_pass_reg, stop_pass_next;
    logic [CW-1:0] age_reg, age_next, stop_age_reg, stop_age_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [COST_W-1:0] freed_reg, freed_next;
    status_t status_reg, status_next;
    rec_t take_rec_reg, take_rec_next;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    logic emit;

    logic [COST_W-1:0] item_cost, rd_cost, freed_sum;
    logic [20:0] limit;
    logic over_budget, evicted, rsp_free;

    function automatic logic [SW-1:0] slot_of(logic [SW-1:0] base, logic [CW-1:0] age);
        logic [CW:0] s;
        s = (CW + 1)'(base) + (CW + 1)'(age);
        if (s >= DEPTH) s = s - DEPTH;
        return s[SW-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    assign item_cost = COST_W'(HEADER_BYTES) + COST_W'(item_reg.payload_length);
    assign rd_cost = COST_W'(HEADER_BYTES) + COST_W'(rd_data_reg.len);
    assign freed_sum = freed_reg + rd_cost;
    // the applied limit is the smaller of the register and the buffer size
    assign limit = ({4'd0, budget_reg} < BUF_CAP) ? {4'd0, budget_reg} : BUF_CAP;
    assign over_budget = (21'(used_reg) + 21'(item_cost)) > limit;
    // planned for removal: every lower-priority record and the stop priority up to the stop age
    assign evicted = (rd_data_reg.pri < stop_pass_reg)
                   || ((rd_data_reg.pri == stop_pass_reg) && (age_reg <= stop_age_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (req_valid) state_next = S_DECIDE;
            S_DECIDE:
                if (item_reg.op == OP_TAKE)
                begin
                    if (count_reg == '0) state_next = rsp_free ? S_IDLE : S_DECIDE;
                    else state_next = S_TAKE_DATA;
                end
                else if (over_budget) state_next = S_PLAN_RD;
                else if (count_reg == CW'(MAX_RECORDS))
                    state_next = rsp_free ? S_IDLE : S_DECIDE;
                else state_next = S_STORE;
            S_TAKE_DATA:
                if (rsp_free) state_next = S_IDLE;
            S_PLAN_RD:
                if (age_reg == count_reg)
                begin
                    if (pass_reg == 2'd2) state_next = rsp_free ? S_IDLE : S_PLAN_RD;
                end
                else state_next = S_PLAN_CHK;
            S_PLAN_CHK:
                if (rd_data_reg.pri == pass_reg && freed_sum >= item_cost)
                    state_next = S_PACK_RD;
                else state_next = S_PLAN_RD;
            S_PACK_RD:
                state_next = (age_reg == count_reg) ? S_STORE : S_PACK_WR;
            S_PACK_WR:
                state_next = S_PACK_RD;
            S_STORE:
                if (rsp_free) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        oldest_next = oldest_reg;
        count_next = count_reg;
        used_next = used_reg;
        pass_next = pass_reg;
        age_next = age_reg;
        stop_pass_next = stop_pass_reg;
        stop_age_next = stop_age_reg;
        kept_next = kept_reg;
        freed_next = freed_reg;
        status_next = status_reg;
        take_rec_next = take_rec_reg;
        rd_addr = slot_of(oldest_reg, age_reg);
        wr_addr = slot_of(oldest_reg, kept_reg);
        wr_data = rd_data_reg;
        wr_en = 1'b0;
        emit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                status_next = ST_OK;
                take_rec_next = '0;
            end
            S_DECIDE:
            begin
                rd_addr = oldest_reg;
                pass_next = '0;
                age_next = '0;
                freed_next = '0;
                if (item_reg.op == OP_TAKE)
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        emit = rsp_free;
                    end
                end
                else if (!over_budget && count_reg == CW'(MAX_RECORDS))
                begin
                    status_next = ST_FULL;
                    emit = rsp_free;
                end
            end
            S_TAKE_DATA:
            begin
                take_rec_next = rd_data_reg;
                emit = rsp_free;
                if (rsp_free)
                begin
                    used_next = used_reg - 17'(rd_cost);
                    count_next = count_reg - CW'(1);
                    oldest_next = slot_of(oldest_reg, CW'(1));
                end
            end
            S_PLAN_RD:
                if (age_reg == count_reg)
                begin
                    if (pass_reg == 2'd2)
                    begin
                        status_next = ST_NOSPACE;
                        emit = rsp_free;
                    end
                    else
                    begin
                        pass_next = pass_reg + 2'd1;
                        age_next = '0;
                    end
                end
            S_PLAN_CHK:
                if (rd_data_reg.pri == pass_reg)
                begin
                    freed_next = freed_sum;
                    if (freed_sum >= item_cost)
                    begin
                        stop_pass_next = pass_reg;
                        stop_age_next = age_reg;
                        age_next = '0;
                        kept_next = '0;
                    end
                    else age_next = age_reg + CW'(1);
                end
                else age_next = age_reg + CW'(1);
            S_PACK_RD:
                if (age_reg == count_reg) count_next = kept_reg;
            S_PACK_WR:
            begin
                // slide survivors toward the oldest end, drop the planned ones
                if (evicted) used_next = used_reg - 17'(rd_cost);
                else
                begin
                    wr_en = 1'b1;
                    kept_next = kept_reg + CW'(1);
                end
                age_next = age_reg + CW'(1);
            end
            S_STORE:
            begin
                wr_addr = slot_of(oldest_reg, count_reg);
                wr_data = '{ts: item_reg.timestamp_ms, len: item_reg.payload_length,
                            pri: item_reg.priority_req, idx: item_reg.event_index};
                emit = rsp_free;
                if (rsp_free)
                begin
                    wr_en = 1'b1;
                    count_next = count_reg + CW'(1);
                    used_next = used_reg + 17'(item_cost);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            budget_reg <= 17'd65536;
            oldest_reg <= '0;
            count_reg <= '0;
            used_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) budget_reg <= cfg_data;
            oldest_reg <= oldest_next;
            count_reg <= count_next;
            used_reg <= used_next;
            if (emit) rsp_valid_reg <= 1'b1;
            else if (!rsp_stall) rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid) item_reg <= req;
        pass_reg <= pass_next;
        age_reg <= age_next;
        stop_pass_reg <= stop_pass_next;
        stop_age_reg <= stop_age_next;
        kept_reg <= kept_next;
        freed_reg <= freed_next;
        status_reg <= status_next;
        take_rec_reg <= take_rec_next;
        if (emit)
        begin
            // hold the result with the counts as they stand after this request
            rsp_reg.status <= status_next;
            rsp_reg.out_event_index <= take_rec_next.idx;
            rsp_reg.out_priority <= take_rec_next.pri;
            rsp_reg.out_length <= take_rec_next.len;
            rsp_reg.out_timestamp <= take_rec_next.ts;
            rsp_reg.bytes_in_use <= used_next;
            rsp_reg.records_held <= 9'(count_next);
        end
    end

endmodule

// ----- rtl/core/perl_checker.sv -----
// Port-level checker for the priority evicting record log, with its bind.
// Depends on perl_pkg and the top level priority_evicting_record_log_unit.
module perl_checker
    import perl_pkg::*;
#(
    parameter int MAX_RECORDS = 256
)(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.records_held) <= 32'(MAX_RECORDS))
        else $error("record count beyond capacity");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |->
        rsp.records_held == '0 && rsp.bytes_in_use == '0 && rsp.out_length == '0)
        else $error("empty result with residue");

    a_bytes_follow_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.records_held == '0 |-> rsp.bytes_in_use == '0)
        else $error("bytes held with no records");

endmodule

bind priority_evicting_record_log_unit perl_checker #(.MAX_RECORDS(MAX_RECORDS)) u_perl_checker (
    .clk(clk),
    .rst_n(rst_n),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
);
